/* sv/ams_pkg.sv */
// Shared constants and types for the adaptive message sampler.
package ams_pkg;

  // Configuration register widths.
  localparam int TARGET_W    = 20;
  localparam int RATIO_REG_W = 17;
  localparam int COUNT_W     = TARGET_W + 1;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  // Register reset values.
  localparam logic [TARGET_W-1:0]    TARGET_RST = TARGET_W'(1000);
  localparam logic [RATIO_REG_W-1:0] RATIO_RST  = RATIO_REG_W'(65536);

  // Register index, taken from paddr[4:3] (8-byte register pitch).
  typedef enum logic [1:0] {
    REG_TARGET_SAMPLES = 2'd0,
    REG_INITIAL_RATIO  = 2'd1,
    REG_START_TIME     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

endpackage

/* sv/ams_ratio_adjust.sv */
// Rate correction: time-since-last-correction to scale factor, scaled and clamped ratio.
module ams_ratio_adjust #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic [TIME_BITS-1:0] now_time_i,
  input  logic [TIME_BITS-1:0] last_time_i,
  input  logic [FRAC_BITS:0]   ratio_i,
  output logic [FRAC_BITS:0]   ratio_o
);

  localparam int RW = FRAC_BITS + 1;
  localparam int PW = 2 * RW;
  localparam int SW = PW - FRAC_BITS;

  localparam logic [TIME_BITS-1:0] LO_T  = TIME_BITS'((3 << FRAC_BITS) / 4);
  localparam logic [TIME_BITS-1:0] HI_T  = TIME_BITS'((5 << FRAC_BITS) / 4);
  localparam logic [RW-1:0]        LO_F  = RW'((3 << FRAC_BITS) / 4);
  localparam logic [RW-1:0]        HI_F  = RW'((5 << FRAC_BITS) / 4);
  localparam logic [RW:0]          ONE_A = (RW + 1)'(1) << FRAC_BITS;
  localparam logic [RW-1:0]        ONE_R = RW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]        ONE_S = SW'(1) << FRAC_BITS;

  logic [TIME_BITS-1:0] dt;
  logic [RW:0]          band_sum;
  logic [RW-1:0]        factor;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        scaled;

  // Elapsed time wraps with the timestamp.
  assign dt       = now_time_i - last_time_i;
  assign band_sum = (RW + 1)'(dt[RW-1:0]) + ONE_A;

  always_comb begin
    if (dt < LO_T) begin
      factor = LO_F;
    end else if (dt > HI_T) begin
      factor = HI_F;
    end else begin
      // average with one second, truncated
      factor = band_sum[RW:1];
    end
  end

  assign prod   = PW'(ratio_i) * PW'(factor);
  assign scaled = prod[PW-1:FRAC_BITS];

  // Cap at one, floor at one LSB so the ratio never locks at zero.
  always_comb begin
    if (scaled > ONE_S) begin
      ratio_o = ONE_R;
    end else if (scaled == '0) begin
      ratio_o = RW'(1);
    end else begin
      ratio_o = scaled[RW-1:0];
    end
  end

endmodule

/* sv/adaptive_message_sampler_core.sv */
// Adaptive message sampler: per-message select decision paced to a target rate.
// Result: registered, valid in the cycle after its timestamp transaction is accepted.
// Throughput: one message per cycle unless the output stalls; the whole state update
//   (rate correction multiply, accumulator add, select compare) is combinational.
// Reset: rst_ni (async, active low) restores the register defaults and loads the
//   sampler state from them; a write to a defined register reloads the state likewise.
module adaptive_message_sampler_core #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // message timestamp channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [TIME_BITS-1:0]         now_time_i,
  // select decision channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         selected_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ams_pkg::PADDR_W-1:0]  paddr,
  input  logic [ams_pkg::PDATA_W-1:0]  pwdata,
  output logic [ams_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int RW = FRAC_BITS + 1;           // ratio width, ONE fits
  localparam int DW = FRAC_BITS + 1;           // accumulator lead, signed, in (-ONE, 0]
  localparam int SW = FRAC_BITS + 2;           // accumulator lead after adding ratio
  localparam int CW = (RW > ams_pkg::RATIO_REG_W) ? RW : ams_pkg::RATIO_REG_W;

  localparam logic [RW-1:0] ONE_R  = RW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] ONE_S  = SW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] RST_C  = CW'(ams_pkg::RATIO_RST);
  localparam logic [RW-1:0] RATIO_LOAD_RST =
    (RST_C > ONE_C) ? ONE_R : ((RST_C == '0) ? RW'(1) : RST_C[RW-1:0]);

  // Configuration registers.
  logic [ams_pkg::TARGET_W-1:0]    target_q, target_d;
  logic [ams_pkg::RATIO_REG_W-1:0] init_ratio_q, init_ratio_d;
  logic [TIME_BITS-1:0]            start_q, start_d;

  // Sampler state. The accumulator is kept as its lead over count*ONE: both
  // drop by target*ONE at a correction, so the lead is unchanged by it.
  logic [TIME_BITS-1:0]            last_time_q, last_time_d;
  logic [RW-1:0]                   ratio_q, ratio_d;
  logic signed [DW-1:0]            lead_q, lead_d;
  logic [ams_pkg::COUNT_W-1:0]     count_q, count_d;

  // Result register.
  logic                            out_valid_q, out_valid_d;
  logic                            selected_q, selected_d;

  ams_pkg::reg_idx_e               reg_idx;
  logic                            cfg_write;
  logic                            in_fire;
  logic                            correct;
  logic [RW-1:0]                   ratio_adj;
  logic [RW-1:0]                   ratio_use;
  logic [ams_pkg::COUNT_W-1:0]     count_cor;
  logic signed [SW-1:0]            lead_sum;
  logic                            select;
  logic [CW-1:0]                   init_ext;
  logic [RW-1:0]                   ratio_load;

  assign pready    = 1'b1;
  assign reg_idx   = ams_pkg::reg_idx_e'(paddr[4:3]);
  assign cfg_write = psel & penable & pwrite;

  // Accept while the result slot is empty or being drained this cycle.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------------
  // Configuration writes and read-back
  // ---------------------------------------------------------------------------
  always_comb begin
    target_d     = target_q;
    init_ratio_d = init_ratio_q;
    start_d      = start_q;
    if (cfg_write) begin
      case (reg_idx)
        ams_pkg::REG_TARGET_SAMPLES: target_d     = pwdata[ams_pkg::TARGET_W-1:0];
        ams_pkg::REG_INITIAL_RATIO:  init_ratio_d = pwdata[ams_pkg::RATIO_REG_W-1:0];
        ams_pkg::REG_START_TIME:     start_d      = pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ams_pkg::REG_TARGET_SAMPLES: prdata = ams_pkg::PDATA_W'(target_q);
      ams_pkg::REG_INITIAL_RATIO:  prdata = ams_pkg::PDATA_W'(init_ratio_q);
      ams_pkg::REG_START_TIME:     prdata = ams_pkg::PDATA_W'(start_q);
      default:                     prdata = '0;
    endcase
  end

  // Ratio loaded on re-initialization: zero becomes one LSB, above ONE caps at ONE.
  assign init_ext = CW'(init_ratio_d);
  always_comb begin
    if (init_ext == '0) begin
      ratio_load = RW'(1);
    end else if (init_ext > ONE_C) begin
      ratio_load = ONE_R;
    end else begin
      ratio_load = init_ext[RW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-message update
  // ---------------------------------------------------------------------------
  // Correct the ratio once the select count has reached the target.
  assign correct = count_q >= ams_pkg::COUNT_W'(target_q);

  ams_ratio_adjust #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ratio_adjust (
    .now_time_i  (now_time_i),
    .last_time_i (last_time_q),
    .ratio_i     (ratio_q),
    .ratio_o     (ratio_adj)
  );

  assign ratio_use = correct ? ratio_adj : ratio_q;
  assign count_cor = correct ? (count_q - ams_pkg::COUNT_W'(target_q)) : count_q;

  // Accumulate the ratio; select while the count trails the accumulator.
  assign lead_sum = SW'(lead_q) + $signed({1'b0, ratio_use});
  assign select   = lead_sum > $signed(SW'(0));

  always_comb begin
    last_time_d = last_time_q;
    ratio_d     = ratio_q;
    lead_d      = lead_q;
    count_d     = count_q;
    if (cfg_write && (reg_idx != ams_pkg::REG_UNUSED)) begin
      // a write to a defined register restarts the sampler from the register values
      last_time_d = start_d;
      ratio_d     = ratio_load;
      lead_d      = '0;
      count_d     = '0;
    end else if (in_fire) begin
      if (correct) begin
        last_time_d = now_time_i;
      end
      ratio_d = ratio_use;
      if (select) begin
        lead_d  = DW'(lead_sum - $signed(ONE_S));
        count_d = count_cor + ams_pkg::COUNT_W'(1);
      end else begin
        lead_d  = DW'(lead_sum);
        count_d = count_cor;
      end
    end
  end

  // Hold the result until taken; load a new one on every accepted transaction.
  always_comb begin
    out_valid_d = out_valid_q;
    selected_d  = selected_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      selected_d  = select;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= ams_pkg::TARGET_RST;
      init_ratio_q <= ams_pkg::RATIO_RST;
      start_q      <= '0;
      last_time_q  <= '0;
      ratio_q      <= RATIO_LOAD_RST;
      lead_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      target_q     <= target_d;
      init_ratio_q <= init_ratio_d;
      start_q      <= start_d;
      last_time_q  <= last_time_d;
      ratio_q      <= ratio_d;
      lead_q       <= lead_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    selected_q <= selected_d;
  end

  assign out_valid_o = out_valid_q;
  assign selected_o  = selected_q;

endmodule

/* dv/tb_adaptive_message_sampler_core.sv */
// Self-checking testbench for the adaptive message sampler core: predicted vs. actual selects.
module tb_adaptive_message_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS = 48;
  localparam int FRAC_BITS = 16;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint DT_LO = 3 * ONE / 4;
  localparam longint DT_HI = 5 * ONE / 4;
  localparam int RAND_MSGS = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [TIME_BITS-1:0]            now_time_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            selected_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ams_pkg::PADDR_W-1:0]     paddr;
  logic [ams_pkg::PDATA_W-1:0]     pwdata;
  logic [ams_pkg::PDATA_W-1:0]     prdata;
  logic                            pready;

  // Predict the select decision of every accepted timestamp and hold the
  // decisions in order until the block delivers them.
  class sampler_model;
    logic [ams_pkg::TARGET_W-1:0]    target;
    logic [ams_pkg::RATIO_REG_W-1:0] init_ratio;
    logic [TIME_BITS-1:0]            start_time;
    logic [TIME_BITS-1:0]            last_time;
    longint                          ratio;
    longint                          accum;
    longint                          count;
    bit                              sel_expected[$];
    int                              errors;

    function new();
      target     = ams_pkg::TARGET_RST;
      init_ratio = ams_pkg::RATIO_RST;
      start_time = '0;
      errors     = 0;
      reload();
    endfunction

    // Load the sampler state from the registers, clamping the ratio to [1 LSB, 1.0].
    function void reload();
      ratio = longint'(init_ratio);
      if (ratio < 1) ratio = 1;
      if (ratio > ONE) ratio = ONE;
      last_time = start_time;
      accum     = 0;
      count     = 0;
    endfunction

    function void set_reg(input ams_pkg::reg_idx_e idx, input logic [63:0] val);
      case (idx)
        ams_pkg::REG_TARGET_SAMPLES: target     = val[ams_pkg::TARGET_W-1:0];
        ams_pkg::REG_INITIAL_RATIO:  init_ratio = val[ams_pkg::RATIO_REG_W-1:0];
        ams_pkg::REG_START_TIME:     start_time = val[TIME_BITS-1:0];
        default: return;
      endcase
      reload();
    endfunction

    function logic [63:0] reg_value(input ams_pkg::reg_idx_e idx);
      case (idx)
        ams_pkg::REG_TARGET_SAMPLES: return 64'(target);
        ams_pkg::REG_INITIAL_RATIO:  return 64'(init_ratio);
        ams_pkg::REG_START_TIME:     return 64'(start_time);
        default:                     return '0;
      endcase
    endfunction

    function void take_msg(input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] dt;
      longint tgt;
      longint dtl;
      longint f;
      longint r;
      bit     sel;
      tgt = longint'(target);
      sel = 1'b0;
      // Correct the ratio once the select count has caught up with the target.
      if (count >= tgt) begin
        dt  = now - last_time;
        dtl = longint'(dt);
        last_time = now;
        if (dtl < DT_LO) f = DT_LO;
        else if (dtl > DT_HI) f = DT_HI;
        else f = (dtl + ONE) >>> 1;
        r = (ratio * f) >>> FRAC_BITS;
        if (r > ONE) r = ONE;
        if (r < 1) r = 1;
        ratio = r;
        count = count - tgt;
        accum = accum - tgt * ONE;
      end
      accum = accum + ratio;
      if (count * ONE < accum) begin
        count = count + 1;
        sel   = 1'b1;
      end
      sel_expected.push_back(sel);
    endfunction

    function void check_sel(input logic actual);
      bit want;
      if (sel_expected.size() == 0) begin
        $error("selected: no result expected, got %0d", actual);
        errors++;
        return;
      end
      want = sel_expected.pop_front();
      if (actual !== want) begin
        $error("selected: expected %0d, got %0d", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return sel_expected.size();
    endfunction
  endclass

  sampler_model sampler = new();

  int  snd_idle;       // percent of cycles the sender idles
  int  rcv_idle;       // percent of cycles the receiver stalls
  bit  hold_req;       // ask the receiver for one long stall
  int  rd_errors;
  int  rand_sent;
  logic [TIME_BITS-1:0] t_now;

  adaptive_message_sampler_core #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .now_time_i  (now_time_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .selected_o  (selected_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it overstays a generous cycle budget.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_adaptive_message_sampler_core: errors");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Monitor: check the delivered decision first, then note the new timestamp,
  // since a result never leaves in the cycle its timestamp is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sampler.check_sel(selected_o);
      if (in_valid_i && in_ready_o) sampler.take_msg(now_time_i);
    end
  end

  // Offer one timestamp, idling at random first; return at the accepting edge.
  task automatic send_msg(input logic [TIME_BITS-1:0] ts);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_time_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted decision has been delivered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sampler.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write a register over APB (setup then access), then read it back.
  task automatic reg_write(input ams_pkg::reg_idx_e idx, input logic [63:0] val);
    logic [63:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ams_pkg::PADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sampler.set_reg(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk_i);
    if (rd !== sampler.reg_value(idx)) begin
      $error("prdata[%s]: expected %0h, got %0h", idx.name(), sampler.reg_value(idx), rd);
      rd_errors++;
    end
  endtask

  // One random phase: new settings, then a run of timestamps paced near the
  // rate the settings call for, with jumps and backward steps mixed in.
  task automatic run_phase();
    int     n;
    int     r;
    bit     any;
    longint eff;
    longint tgt1;
    longint nominal;
    logic [TIME_BITS-1:0] step;
    logic [ams_pkg::TARGET_W-1:0]    tgt;
    logic [ams_pkg::RATIO_REG_W-1:0] rat;
    drain_results();
    any = 1'b0;
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 10) tgt = '0;
      else if (r < 80) tgt = ams_pkg::TARGET_W'($urandom_range(1, 24));
      else if (r < 95) tgt = ams_pkg::TARGET_W'($urandom_range(25, 3000));
      else tgt = ams_pkg::TARGET_W'($urandom_range(999000, 1048575));
      reg_write(ams_pkg::REG_TARGET_SAMPLES, 64'(tgt));
      any = 1'b1;
    end
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 40) rat = ams_pkg::RATIO_REG_W'(65536);
      else if (r < 85) rat = ams_pkg::RATIO_REG_W'($urandom_range(1, 65535));
      else if (r < 92) rat = '0;
      else rat = ams_pkg::RATIO_REG_W'($urandom_range(65537, 131071));
      reg_write(ams_pkg::REG_INITIAL_RATIO, 64'(rat));
      any = 1'b1;
    end
    if (!any || $urandom_range(99) < 50) begin
      reg_write(ams_pkg::REG_START_TIME, 64'(TIME_BITS'({$urandom, $urandom})));
    end

    // Pace so that about target selections land in one second.
    eff = longint'(sampler.init_ratio);
    if (eff < 1) eff = 1;
    if (eff > ONE) eff = ONE;
    tgt1 = (sampler.target == 0) ? 1 : longint'(sampler.target);
    nominal = eff * $urandom_range(1, 6) / (3 * tgt1);
    if (nominal < 1) nominal = 1;
    t_now = sampler.start_time;

    n = $urandom_range(40, 120);
    repeat (n) begin
      // Pick the idle pattern from how far the random part has come.
      if (rand_sent < RAND_MSGS / 3) begin
        snd_idle = 29; rcv_idle = 61;
      end else if (rand_sent < 2 * RAND_MSGS / 3) begin
        snd_idle = 61; rcv_idle = 29;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      // Stall the receiver for a long stretch once the idle-free third is under way.
      if (rand_sent == RAND_MSGS * 3 / 4) hold_req = 1'b1;
      // Pause the sender once until every decision is back.
      if (rand_sent == RAND_MSGS / 2) drain_results();
      r = $urandom_range(99);
      if (r < 4) t_now = TIME_BITS'({$urandom, $urandom});
      else if (r < 7) t_now = t_now - TIME_BITS'($urandom_range(1, 70000));
      else begin
        step  = TIME_BITS'($urandom_range(0, int'(2 * nominal)));
        t_now = t_now + step;
      end
      send_msg(t_now);
      rand_sent++;
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    now_time_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    hold_req   = 1'b0;
    rd_errors  = 0;
    rand_sent  = 0;
    snd_idle   = 29;
    rcv_idle   = 61;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: register defaults first.
    send_msg(48'h0);
    send_msg(48'h1);

    // Small target: walk dt below the band, on both band edges, above it, and backwards.
    drain_results();
    reg_write(ams_pkg::REG_TARGET_SAMPLES, 64'd2);
    t_now = 48'h100;
    send_msg(t_now);
    t_now = t_now + 48'h100; send_msg(t_now);
    t_now = t_now + 48'h100; send_msg(t_now);
    t_now = t_now + TIME_BITS'(DT_LO); send_msg(t_now);
    t_now = t_now + TIME_BITS'(DT_HI); send_msg(t_now);
    t_now = t_now + 48'd60000; send_msg(t_now);
    t_now = t_now + 48'd200000; send_msg(t_now);
    t_now = t_now - 48'd5; send_msg(t_now);
    send_msg(48'hFFFF_FFFF_FFFF);
    send_msg(48'h0);

    // Zero ratio loads 1 LSB; zero target corrects on every message, so the
    // ratio keeps shrinking and must hold at its floor.
    drain_results();
    reg_write(ams_pkg::REG_INITIAL_RATIO, 64'd0);
    reg_write(ams_pkg::REG_TARGET_SAMPLES, 64'd0);
    send_msg(48'd10);
    send_msg(48'd20);
    send_msg(48'd30);
    send_msg(48'd40);

    // Ratio above 1.0 clamps; start time at the top of the range wraps.
    drain_results();
    reg_write(ams_pkg::REG_INITIAL_RATIO, 64'd131071);
    reg_write(ams_pkg::REG_START_TIME, 64'hFFFF_FFFF_FFFF);
    send_msg(48'h0);
    send_msg(48'd10);
    send_msg(48'd70000);

    // Largest target with the smallest ratio: no correction in sight.
    drain_results();
    reg_write(ams_pkg::REG_TARGET_SAMPLES, 64'd1048575);
    reg_write(ams_pkg::REG_INITIAL_RATIO, 64'd1);
    send_msg(48'hAAAA_5555_AAAA);
    send_msg(48'h5555_AAAA_5555);

    // Random phases until the message budget is spent.
    while (rand_sent < RAND_MSGS) run_phase();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sampler.errors == 0 && rd_errors == 0 && sampler.pending() == 0) begin
      $display("tb_adaptive_message_sampler_core: clean");
    end else begin
      $display("tb_adaptive_message_sampler_core: errors");
    end
    $finish;
  end

endmodule
